[hw/rtl/flat_json_object_tokenizer_top_assert.svh]
// ----------------------------------------------------------------------------
// Flat JSON tokenizer assertion macros
// Shared same-cycle and next-cycle implication property templates.
// ----------------------------------------------------------------------------
`ifndef FLAT_JSON_OBJECT_TOKENIZER_TOP_ASSERT_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FJOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FJOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fjot_pkg.sv]
// ----------------------------------------------------------------------------
// fjot_pkg
// Types and character constants for the flat JSON object tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fjot_pkg;

  // Parse modes
  typedef enum logic [3:0] {
    MODE_SEEK  = 4'd0,
    MODE_GAP   = 4'd1,
    MODE_KEY   = 4'd2,
    MODE_COLON = 4'd3,
    MODE_PREWS = 4'd4,
    MODE_BARE  = 4'd5,
    MODE_STR   = 4'd6,
    MODE_ESC   = 4'd7,
    MODE_DONE  = 4'd8
  } mode_t;

  // Token kinds
  typedef enum logic [2:0] {
    TK_KEYCHAR = 3'd0,
    TK_KEYEND  = 3'd1,
    TK_VALCHAR = 3'd2,
    TK_PAIREND = 3'd3,
    TK_OBJEND  = 3'd4,
    TK_FINISH  = 3'd5
  } tok_kind_t;

  // Characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  // Most tokens one byte can produce
  localparam int unsigned MAX_TOKS = 3;

  // Input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    tok_kind_t  token_kind;
    logic [7:0] token_char;
    logic       parse_ok;
    logic       last_of_run;
  } out_item_t;

  // One token inside a bundle
  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] chr;
    logic       ok;
  } tok_t;

  // All tokens caused by one byte
  typedef struct packed {
    logic [1:0]                cnt;
    tok_t [MAX_TOKS-1:0]       toks;
  } bundle_t;

endpackage

[hw/rtl/fjot_front.sv]
// ----------------------------------------------------------------------------
// fjot_front
// Accepts text bytes, steps the parse mode and builds the token bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fjot_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  fjot_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output fjot_pkg::bundle_t q_data
);
  import fjot_pkg::*;

  mode_t      mode_r;
  mode_t      mode_nxt;
  bundle_t    bnd;
  logic       acc;
  logic [7:0] c;
  logic       last;
  logic       gap_blank;

  // Append one token to a bundle, dropping beyond the limit
  function automatic bundle_t add_tok(input bundle_t b, input tok_kind_t k,
                                      input logic [7:0] ch, input logic ok);
    bundle_t r;
    r = b;
    if (b.cnt != 2'(MAX_TOKS)) begin
      r.toks[b.cnt] = '{kind: k, chr: ch, ok: ok};
      r.cnt         = b.cnt + 2'd1;
    end
    return r;
  endfunction

  assign c    = in_data.in_byte;
  assign last = in_data.end_of_text;
  assign acc  = in_push && !q_full;

  assign gap_blank = (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) ||
                     (c == CH_TAB) || (c == CH_COMMA);

  // Step the mode and collect tokens
  always_comb begin
    bnd      = '0;
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_SEEK: begin
        if (c == CH_LBRACE) mode_nxt = MODE_GAP;
      end
      MODE_GAP: begin
        if (gap_blank) begin
          mode_nxt = MODE_GAP;
        end else if (c == CH_RBRACE) begin
          bnd      = add_tok(bnd, TK_OBJEND, 8'h00, 1'b0);
          bnd      = add_tok(bnd, TK_FINISH, 8'h00, 1'b1);
          mode_nxt = MODE_DONE;
        end else if (c == CH_QUOTE) begin
          mode_nxt = MODE_KEY;
        end else begin
          bnd      = add_tok(bnd, TK_FINISH, 8'h00, 1'b0);
          mode_nxt = MODE_DONE;
        end
      end
      MODE_KEY: begin
        if (c == CH_QUOTE) begin
          bnd      = add_tok(bnd, TK_KEYEND, 8'h00, 1'b0);
          mode_nxt = MODE_COLON;
        end else begin
          bnd = add_tok(bnd, TK_KEYCHAR, c, 1'b0);
        end
      end
      MODE_COLON: begin
        if (c == CH_COLON) mode_nxt = MODE_PREWS;
      end
      MODE_PREWS, MODE_BARE: begin
        if (mode_r == MODE_PREWS && (c == CH_SPACE || c == CH_TAB)) begin
          mode_nxt = MODE_PREWS;
        end else if (mode_r == MODE_PREWS && c == CH_QUOTE) begin
          mode_nxt = MODE_STR;
        end else if (c == CH_COMMA || c == CH_SPACE) begin
          bnd      = add_tok(bnd, TK_PAIREND, 8'h00, 1'b0);
          mode_nxt = MODE_GAP;
        end else if (c == CH_RBRACE) begin
          bnd      = add_tok(bnd, TK_PAIREND, 8'h00, 1'b0);
          bnd      = add_tok(bnd, TK_OBJEND, 8'h00, 1'b0);
          bnd      = add_tok(bnd, TK_FINISH, 8'h00, 1'b1);
          mode_nxt = MODE_DONE;
        end else begin
          bnd      = add_tok(bnd, TK_VALCHAR, c, 1'b0);
          mode_nxt = MODE_BARE;
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          bnd      = add_tok(bnd, TK_PAIREND, 8'h00, 1'b0);
          mode_nxt = MODE_GAP;
        end else if (c == CH_BSLASH && !last) begin
          mode_nxt = MODE_ESC;
        end else begin
          bnd = add_tok(bnd, TK_VALCHAR, c, 1'b0);
        end
      end
      MODE_ESC: begin
        bnd      = add_tok(bnd, TK_VALCHAR, (c == CH_LOW_N) ? CH_LF : c, 1'b0);
        mode_nxt = MODE_STR;
      end
      default: begin
        mode_nxt = MODE_DONE;
      end
    endcase

    // Close the text on the flagged byte
    if (last) begin
      unique case (mode_nxt)
        MODE_SEEK, MODE_KEY, MODE_COLON: begin
          bnd = add_tok(bnd, TK_FINISH, 8'h00, 1'b0);
        end
        MODE_GAP: begin
          bnd = add_tok(bnd, TK_FINISH, 8'h00, 1'b1);
        end
        MODE_PREWS, MODE_BARE, MODE_STR, MODE_ESC: begin
          bnd = add_tok(bnd, TK_PAIREND, 8'h00, 1'b0);
          bnd = add_tok(bnd, TK_FINISH, 8'h00, 1'b1);
        end
        default: begin
          bnd = bnd;
        end
      endcase
      mode_nxt = MODE_SEEK;
    end
  end

  // Queue only bundles that hold tokens
  assign q_push = acc && (bnd.cnt != 2'd0);
  assign q_data = bnd;

  // Advance the parse mode on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SEEK;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

[hw/rtl/fjot_fifo.sv]
// ----------------------------------------------------------------------------
// fjot_fifo
// Short register queue of token bundles between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "flat_json_object_tokenizer_top_assert.svh"

module fjot_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  fjot_pkg::bundle_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output fjot_pkg::bundle_t rd_data,
  output logic              empty
);
  import fjot_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Store incoming bundles
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `FJOT_ASSERT_NOW(a_no_overflow, clk, rst_n, wr_en, !full, "bundle pushed into full queue")
  `FJOT_ASSERT_NOW(a_no_underflow, clk, rst_n, rd_en, !empty, "bundle popped from empty queue")
  `FJOT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

[hw/rtl/fjot_back.sv]
// ----------------------------------------------------------------------------
// fjot_back
// Output stage: unpacks queued bundles into single token transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "flat_json_object_tokenizer_top_assert.svh"

module fjot_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  fjot_pkg::bundle_t   q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output fjot_pkg::out_item_t out_data
);
  import fjot_pkg::*;

  bundle_t    bundle_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       head_last;
  logic       take;
  logic       pop_ok;
  tok_t       cur;

  assign cur       = bundle_r.toks[idx_r];
  assign head_last = valid_r && (idx_r == bundle_r.cnt - 2'd1);
  assign pop_ok    = out_pop && valid_r;
  assign take      = !valid_r || (pop_ok && head_last);
  assign q_pop     = take && !q_empty;

  assign out_empty            = !valid_r;
  assign out_data.token_kind  = cur.kind;
  assign out_data.token_char  = cur.chr;
  assign out_data.parse_ok    = cur.ok;
  assign out_data.last_of_run = head_last;

  // Load the next bundle or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (pop_ok) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // Hold the bundle payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      bundle_r <= q_data;
    end
  end

  `FJOT_ASSERT_NOW(a_idx_in_bundle, clk, rst_n, valid_r, (bundle_r.cnt != 2'd0) && (idx_r < bundle_r.cnt), "token index outside bundle")
  `FJOT_ASSERT_NEXT(a_run_continues, clk, rst_n, pop_ok && !head_last, valid_r && (idx_r == $past(idx_r) + 2'd1), "bundle run cut short")
  `FJOT_ASSERT_NOW(a_ok_only_finish, clk, rst_n, valid_r && (cur.kind != TK_FINISH), !cur.ok, "success flag on non-finish token")

endmodule

[hw/rtl/flat_json_object_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer_top
// The first token of a byte is offered after it passes the bundle queue and output stage.
// Throughput: 1 byte per cycle while the bundle queue has room; tokens leave at
//   1 per cycle from the output stage while out_pop is high.
// Reset: synchronous rst_n low sets the mode to seeking '{' and empties queue
//   and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flat_json_object_tokenizer_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  fjot_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output fjot_pkg::out_item_t out_data
);
  import fjot_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wr_data;
  bundle_t q_rd_data;

  assign in_full = q_full;

  // Classify bytes and step the parse mode
  fjot_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  // Decouple front and back
  fjot_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Deliver tokens one transaction at a time
  fjot_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for flat_json_object_tokenizer_top. Streams directed and
// random JSON texts one byte per transaction and predicts the token stream
// with a cycle-free parser model. Compares every popped token field by field.
// Applies random push gaps and pop stalls, except while idling is off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fjot_pkg::*;

  localparam int unsigned RANDOM_BYTES = 300;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  // Parser model state and token scoreboard
  mode_t       parse_mode = MODE_SEEK;
  out_item_t   token_q[$];
  logic [7:0]  text_q[$];
  int unsigned bytes_sent = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned pop_stall = 0;
  bit          no_idle = 1'b0;

  flat_json_object_tokenizer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random byte outside a small excluded set
  function automatic logic [7:0] pick_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                           logic [7:0] d, logic [7:0] e);
    logic [7:0] r;
    do begin
      r = 8'($urandom_range(0, 255));
    end while (r == a || r == b || r == c || r == d || r == e);
    return r;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_LF;
      default: return CH_COMMA;
    endcase
  endfunction

  // Append one byte to the staged text
  function automatic void stage_byte(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic out_item_t make_tok(tok_kind_t kind, logic [7:0] chr, logic ok);
    out_item_t t;
    t.token_kind  = kind;
    t.token_char  = chr;
    t.parse_ok    = ok;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  // Advance the parser model by one byte and queue the tokens it yields
  task automatic predict_tokens(in_item_t item);
    out_item_t  run[3];
    int         n;
    logic [7:0] c;
    logic       eot;
    n   = 0;
    c   = item.in_byte;
    eot = item.end_of_text;
    case (parse_mode)
      MODE_SEEK: begin
        if (c == CH_LBRACE) parse_mode = MODE_GAP;
      end
      MODE_GAP: begin
        if (c == CH_RBRACE) begin
          run[n++] = make_tok(TK_OBJEND, 8'h00, 1'b0);
          run[n++] = make_tok(TK_FINISH, 8'h00, 1'b1);
          parse_mode = MODE_DONE;
        end else if (c == CH_QUOTE) begin
          parse_mode = MODE_KEY;
        end else if (!(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA})) begin
          run[n++] = make_tok(TK_FINISH, 8'h00, 1'b0);
          parse_mode = MODE_DONE;
        end
      end
      MODE_KEY: begin
        if (c == CH_QUOTE) begin
          run[n++] = make_tok(TK_KEYEND, 8'h00, 1'b0);
          parse_mode = MODE_COLON;
        end else begin
          run[n++] = make_tok(TK_KEYCHAR, c, 1'b0);
        end
      end
      MODE_COLON: begin
        if (c == CH_COLON) parse_mode = MODE_PREWS;
      end
      MODE_PREWS, MODE_BARE: begin
        if (parse_mode == MODE_PREWS && (c == CH_SPACE || c == CH_TAB)) begin
          // skip leading blanks of the value
        end else if (parse_mode == MODE_PREWS && c == CH_QUOTE) begin
          parse_mode = MODE_STR;
        end else if (c == CH_COMMA || c == CH_SPACE) begin
          run[n++] = make_tok(TK_PAIREND, 8'h00, 1'b0);
          parse_mode = MODE_GAP;
        end else if (c == CH_RBRACE) begin
          run[n++] = make_tok(TK_PAIREND, 8'h00, 1'b0);
          run[n++] = make_tok(TK_OBJEND, 8'h00, 1'b0);
          run[n++] = make_tok(TK_FINISH, 8'h00, 1'b1);
          parse_mode = MODE_DONE;
        end else begin
          run[n++] = make_tok(TK_VALCHAR, c, 1'b0);
          parse_mode = MODE_BARE;
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          run[n++] = make_tok(TK_PAIREND, 8'h00, 1'b0);
          parse_mode = MODE_GAP;
        end else if (c == CH_BSLASH && !eot) begin
          parse_mode = MODE_ESC;
        end else begin
          run[n++] = make_tok(TK_VALCHAR, c, 1'b0);
        end
      end
      MODE_ESC: begin
        run[n++] = make_tok(TK_VALCHAR, (c == CH_LOW_N) ? CH_LF : c, 1'b0);
        parse_mode = MODE_STR;
      end
      default: parse_mode = MODE_DONE;
    endcase

    // Close the text on the flagged byte
    if (eot) begin
      case (parse_mode)
        MODE_SEEK, MODE_KEY, MODE_COLON: run[n++] = make_tok(TK_FINISH, 8'h00, 1'b0);
        MODE_GAP: run[n++] = make_tok(TK_FINISH, 8'h00, 1'b1);
        MODE_PREWS, MODE_BARE, MODE_STR, MODE_ESC: begin
          run[n++] = make_tok(TK_PAIREND, 8'h00, 1'b0);
          run[n++] = make_tok(TK_FINISH, 8'h00, 1'b1);
        end
        default: ;
      endcase
      parse_mode = MODE_SEEK;
    end

    if (n > 0) run[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) token_q = {token_q, run[i]};
  endtask

  // Push one byte transaction after a random gap and wait for acceptance
  task automatic send_byte(logic [7:0] b, logic eot);
    in_item_t    item;
    int unsigned gap;
    item.in_byte     = b;
    item.end_of_text = eot;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_tokens(item);
    bytes_sent++;
  endtask

  // Send the staged text, flagging its final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic test_seek_and_abort();
    // junk before the brace, bad byte in the gap, ignored bytes after abort
    text_q = '{8'hFF, CH_LBRACE, "x", "y", CH_RBRACE};
    send_text();
    // text ending before any brace
    text_q = '{8'h00};
    send_text();
  endtask

  task automatic test_string_value();
    // raw backslash in the key, junk before colon, escapes in the value
    text_q = '{CH_LBRACE, CH_TAB, CH_QUOTE, "k", CH_BSLASH, CH_QUOTE, "=", CH_COLON,
               CH_SPACE, CH_QUOTE, CH_BSLASH, CH_LOW_N, CH_BSLASH, CH_QUOTE, CH_BSLASH,
               "q", CH_QUOTE, CH_RBRACE};
    send_text();
  endtask

  task automatic test_empty_values();
    // empty keys, empty bare values ended by comma and by closing brace
    text_q = '{CH_LBRACE, CH_QUOTE, CH_QUOTE, CH_COLON, CH_COMMA, CH_CR, CH_LF,
               CH_QUOTE, CH_QUOTE, CH_COLON, CH_RBRACE};
    send_text();
  endtask

  task automatic test_text_endings();
    text_q = '{CH_LBRACE};
    send_text();
    text_q = '{CH_LBRACE, CH_QUOTE, "a"};
    send_text();
    text_q = '{CH_LBRACE, CH_QUOTE, CH_QUOTE};
    send_text();
    text_q = '{CH_LBRACE, CH_QUOTE, CH_QUOTE, CH_COLON};
    send_text();
    text_q = '{CH_LBRACE, CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_BSLASH};
    send_text();
    text_q = '{CH_LBRACE, CH_QUOTE, CH_QUOTE, CH_COLON, "7"};
    send_text();
  endtask

  // Stage a well-formed object with random content, then maybe damage it
  task automatic build_object();
    int unsigned npairs;
    int unsigned keep;
    text_q.delete();
    repeat ($urandom_range(0, 2))
      stage_byte(pick_byte(CH_LBRACE, CH_LBRACE, CH_LBRACE, CH_LBRACE, CH_LBRACE));
    stage_byte(CH_LBRACE);
    npairs = $urandom_range(0, 3);
    for (int p = 0; p < npairs; p++) begin
      repeat ($urandom_range(0, 2)) stage_byte(pick_blank());
      stage_byte(CH_QUOTE);
      repeat ($urandom_range(0, 3))
        stage_byte(pick_byte(CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE));
      stage_byte(CH_QUOTE);
      if ($urandom_range(0, 3) == 0)
        stage_byte(pick_byte(CH_COLON, CH_COLON, CH_COLON, CH_COLON, CH_COLON));
      stage_byte(CH_COLON);
      if ($urandom_range(0, 2) == 0) stage_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      if ($urandom_range(0, 1)) begin
        // quoted value with occasional escapes
        stage_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 3) == 0) begin
            stage_byte(CH_BSLASH);
            case ($urandom_range(0, 4))
              0: stage_byte(CH_LOW_N);
              1: stage_byte(CH_QUOTE);
              2: stage_byte(CH_BSLASH);
              3: stage_byte("/");
              default: stage_byte(8'($urandom_range(0, 255)));
            endcase
          end else begin
            stage_byte(pick_byte(CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_QUOTE, CH_QUOTE));
          end
        end
        stage_byte(CH_QUOTE);
      end else begin
        // bare value, possibly empty
        repeat ($urandom_range(0, 3))
          stage_byte(pick_byte(CH_COMMA, CH_SPACE, CH_RBRACE, CH_TAB, CH_QUOTE));
        if (p != npairs - 1 || $urandom_range(0, 1))
          stage_byte($urandom_range(0, 1) ? CH_COMMA : CH_SPACE);
      end
    end
    repeat ($urandom_range(0, 1)) stage_byte(pick_blank());
    stage_byte(CH_RBRACE);
    // trailing bytes after the closing brace
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) stage_byte(8'($urandom_range(0, 255)));
    // corrupt one byte or cut the text short
    if ($urandom_range(0, 5) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0) begin
      keep = $urandom_range(1, text_q.size());
      while (text_q.size() > keep) text_q.delete(text_q.size() - 1);
    end
  endtask

  task automatic test_random_texts();
    int unsigned target;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // pure noise text
        text_q.delete();
        repeat ($urandom_range(1, 6)) stage_byte(8'($urandom_range(0, 255)));
      end else begin
        build_object();
      end
      send_text();
    end
    no_idle = 1'b0;
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_stall > 0) begin
      out_pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      out_pop <= 1'b1;
      pop_stall <= pick_gap();
    end
  end

  // Check each popped token against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected token: expected none, actual %h", $time, out_data);
      end else begin
        want = token_q.pop_front();
        if (out_data != want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            if (out_data.token_kind != want.token_kind)
              $display("%0t: token_kind mismatch: expected %0d, actual %0d",
                       $time, want.token_kind, out_data.token_kind);
            if (out_data.token_char != want.token_char)
              $display("%0t: token_char mismatch: expected %h, actual %h",
                       $time, want.token_char, out_data.token_char);
            if (out_data.parse_ok != want.parse_ok)
              $display("%0t: parse_ok mismatch: expected %b, actual %b",
                       $time, want.parse_ok, out_data.parse_ok);
            if (out_data.last_of_run != want.last_of_run)
              $display("%0t: last_of_run mismatch: expected %b, actual %b",
                       $time, want.last_of_run, out_data.last_of_run);
          end
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("flat_json_object_tokenizer_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_seek_and_abort();
    test_string_value();
    test_empty_values();
    test_text_endings();
    test_random_texts();

    // Drop push and drain the remaining tokens
    @(negedge clk);
    in_push <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("flat_json_object_tokenizer_top test passed");
    end else begin
      $display("flat_json_object_tokenizer_top test failed");
    end
    $finish;
  end

endmodule
